/* hw/rtl/tdss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_pkg
// Shared types, constants and the seven-segment table of the serializer.
// ----------------------------------------------------------------------------
package tdss_pkg;

  localparam int unsigned FrameBits = 16;
  localparam int unsigned CntBits   = 4;

  localparam logic [7:0] LimitAccepted = 8'd99;
  localparam logic [7:0] BlankPattern  = 8'h00;
  // floor(n * 205 / 2048) == floor(n / 10) for every n below 1029
  localparam logic [7:0] RecipTen      = 8'd205;
  localparam logic [3:0] Ten           = 4'd10;

  // Encoded frame handed from the encoder to the shift stage
  typedef struct packed {
    logic [FrameBits-1:0] frame;     // inverted bits, first shifted bit at the top
    logic                 rejected;
  } tdss_item_t;

  // Segment a in bit 0 ... segment g in bit 6, decimal point never lit
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'h3f;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5b;
      4'd3:    pat = 8'h4f;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6d;
      4'd6:    pat = 8'h7d;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7f;
      4'd9:    pat = 8'h6f;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

/* hw/rtl/two_digit_seven_segment_serializer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_digit_seven_segment_serializer_unit
// Byte to two-digit seven-segment serial stream for cascaded shift registers.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one number per transaction (tdata[7:0]).
//   m_axis carries one shift-clock bit per transaction: tdata[0] is the data
//   line level (0 lights a segment), tlast marks the bit after which to pulse
//   the latch, tuser flags a number above 99.
//   A number from 0 to 99 yields 16 transactions, units byte first, then tens
//   byte, each MSB first; a zero tens digit is blanked (all ones).
//   A number above 99 yields a single transaction with tuser high.
// A number passes the input register, then the output register, which takes
//   its encoded frame once the shift stage is idle.
// The output shift stage emits one bit per cycle while m_axis is not stalled.
//   One further number waits in the input register, so a stream of numbers
//   flows without gaps.
// Reset clears both valid stages; no output is pending afterwards.
// A stall on m_axis holds the current bit; s_axis tready drops once the input
//   register is full.
// ----------------------------------------------------------------------------
module two_digit_seven_segment_serializer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] number
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] serial_bit, [7:1] zero
  output logic       m_axis_tlast,   // latch_after
  output logic       m_axis_tuser    // [0] rejected
);

  logic                 item_valid;
  logic                 item_take;
  tdss_pkg::tdss_item_t item;
  logic                 serial_bit;

  tdss_encoder u_encoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_number_i  (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  tdss_shifter u_shifter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_bit_o    (serial_bit),
    .out_last_o   (m_axis_tlast),
    .out_rej_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, serial_bit};

endmodule

/* hw/rtl/tdss_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_encoder
// Input register, range check, digit split and segment lookup.
// ----------------------------------------------------------------------------
module tdss_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_number_i,
  output logic                item_valid_o,
  input  logic                item_take_i,
  output tdss_pkg::tdss_item_t item_o
);

  logic       valid_q, valid_d;
  logic [7:0] number_q, number_d;
  logic [15:0] prod;
  logic [3:0]  tens;
  logic [7:0]  tens_x10;
  logic [3:0]  units;
  logic [7:0]  units_pat;
  logic [7:0]  tens_pat;

  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d  = valid_q;
    number_d = number_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        number_d = in_number_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    number_q <= number_d;
  end

  // divide by ten through the reciprocal; only in-range values are used
  assign prod     = 16'(number_q) * 16'(tdss_pkg::RecipTen);
  assign tens     = prod[14:11];
  assign tens_x10 = 8'(tens) * 8'(tdss_pkg::Ten);
  assign units    = 4'(number_q - tens_x10);

  assign units_pat = tdss_pkg::seg_pattern(units);
  assign tens_pat  = (tens == 4'd0) ? tdss_pkg::BlankPattern : tdss_pkg::seg_pattern(tens);

  assign item_valid_o   = valid_q;
  assign item_o.rejected = (number_q > tdss_pkg::LimitAccepted);
  assign item_o.frame    = {~units_pat, ~tens_pat};

endmodule

/* hw/rtl/tdss_shifter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdss_shifter
// Serializes one encoded frame into sixteen output transactions, or a rejected item into one.
// ----------------------------------------------------------------------------
module tdss_shifter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 item_take_o,
  input  tdss_pkg::tdss_item_t item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_bit_o,
  output logic                 out_last_o,
  output logic                 out_rej_o
);

  logic                                out_valid_q, out_valid_d;
  logic                                bit_q, bit_d;
  logic                                last_q, last_d;
  logic                                rej_q, rej_d;
  logic [tdss_pkg::FrameBits-2:0]      sr_q, sr_d;
  logic [tdss_pkg::CntBits-1:0]        cnt_q, cnt_d;
  logic                                beat;
  logic                                free;

  assign beat        = out_valid_q && out_ready_i;
  // the output register frees up when empty or when its final bit is taken
  assign free        = !out_valid_q || (beat && (cnt_q == '0));
  assign item_take_o = free && item_valid_i;

  always_comb begin
    out_valid_d = out_valid_q;
    bit_d       = bit_q;
    last_d      = last_q;
    rej_d       = rej_q;
    sr_d        = sr_q;
    cnt_d       = cnt_q;
    if (free) begin
      out_valid_d = item_valid_i;
      if (item_valid_i) begin
        if (item_i.rejected) begin
          bit_d  = 1'b0;
          last_d = 1'b0;
          rej_d  = 1'b1;
          cnt_d  = '0;
        end else begin
          bit_d  = item_i.frame[tdss_pkg::FrameBits-1];
          sr_d   = item_i.frame[tdss_pkg::FrameBits-2:0];
          last_d = 1'b0;
          rej_d  = 1'b0;
          cnt_d  = tdss_pkg::CntBits'(tdss_pkg::FrameBits - 1);
        end
      end
    end else if (beat) begin
      // advance to the next bit; mark the final one for the latch
      bit_d  = sr_q[tdss_pkg::FrameBits-2];
      sr_d   = {sr_q[tdss_pkg::FrameBits-3:0], 1'b0};
      cnt_d  = cnt_q - tdss_pkg::CntBits'(1);
      last_d = (cnt_q == tdss_pkg::CntBits'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    last_q <= last_d;
    rej_q  <= rej_d;
    sr_q   <= sr_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_bit_o   = bit_q;
  assign out_last_o  = last_q;
  assign out_rej_o   = rej_q;

`ifndef SYNTHESIS
  a_cnt_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> out_valid_q)
    else $error("bits pending without a valid output");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> (cnt_q == '0 && !rej_q))
    else $error("latch mark before the final bit");

  a_rej_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rej_q) |-> (cnt_q == '0 && !last_q))
    else $error("rejection result not single");

  a_no_take_midframe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && cnt_q != '0) |-> !item_take_o)
    else $error("new frame loaded while bits remain");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-digit seven-segment serializer. A driver
// feeds numbers (a directed set of extremes, every digit in both places,
// blanked tens and rejected values, then a random mix) with random gaps. A
// monitor stalls the output at random and compares each serial bit, its latch
// marker and its reject flag against a predicted bit stream.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic serial_bit;
    logic latch_after;
    logic rejected;
  } shift_bit_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;    // [7:0] number
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [0] serial_bit, [7:1] zero
  logic       m_axis_tlast;           // latch_after
  logic       m_axis_tuser;           // [0] rejected

  logic [7:0]  pending_numbers[$];
  shift_bit_t  expected_bits[$];

  int unsigned total_numbers;
  int unsigned sent_numbers;
  int unsigned rejected_numbers;
  int unsigned blanked_numbers;
  int unsigned bits_seen;
  int unsigned mismatches;
  int unsigned in_wait;
  int unsigned in_calm;
  int unsigned out_stall;
  int unsigned out_calm;

  two_digit_seven_segment_serializer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // Segment a in bit 0 ... g in bit 6; decimal point stays dark
  function automatic logic [7:0] digit_segments(input int unsigned digit);
    case (digit)
      0:       return 8'h3f;
      1:       return 8'h06;
      2:       return 8'h5b;
      3:       return 8'h4f;
      4:       return 8'h66;
      5:       return 8'h6d;
      6:       return 8'h7d;
      7:       return 8'h07;
      8:       return 8'h7f;
      default: return 8'h6f;
    endcase
  endfunction

  // Queue the bits the shift registers should receive for one number
  task automatic predict_shift_bits(input logic [7:0] number);
    logic [15:0] pattern;
    shift_bit_t  b;
    if (number > tdss_pkg::LimitAccepted) begin
      b.serial_bit  = 1'b0;
      b.latch_after = 1'b0;
      b.rejected    = 1'b1;
      expected_bits.push_back(b);
      rejected_numbers++;
    end else begin
      if (number / 10 == 0) blanked_numbers++;
      // units byte goes out first, so it sits in the upper half
      pattern = {digit_segments(number % 10),
                 (number / 10 == 0) ? 8'h00 : digit_segments(number / 10)};
      for (int k = 15; k >= 0; k--) begin
        b.serial_bit  = ~pattern[k];
        b.latch_after = (k == 0);
        b.rejected    = 1'b0;
        expected_bits.push_back(b);
      end
    end
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at bit %0d: %s expected %0h got %0h", bits_seen, what, want, got);
  endtask

  // Driver: hold the number until the transaction completes, then idle a while
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'd0;
      in_wait       <= 0;
      in_calm       <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || !s_axis_tvalid) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_shift_bits(s_axis_tdata);
        void'(pending_numbers.pop_front());
        sent_numbers++;
      end
      if (in_wait > 0) begin
        in_wait       <= in_wait - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_numbers.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_numbers[0];
        if (in_calm > 0) begin
          in_calm <= in_calm - 1;
          in_wait <= 0;
        end else if ($urandom_range(0, 15) == 0) begin
          in_calm <= $urandom_range(10, 30);
          in_wait <= 0;
        end else begin
          in_wait <= pick_gap();
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each bit transaction and stall the output at random
  always @(posedge clk_i or negedge rst_ni) begin
    shift_bit_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_stall     <= 0;
      out_calm      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bits.size() == 0) begin
          flag_mismatch("unexpected transaction, tdata", 0, m_axis_tdata);
        end else begin
          want = expected_bits.pop_front();
          if (m_axis_tdata !== {7'd0, want.serial_bit})
            flag_mismatch("tdata", {7'd0, want.serial_bit}, m_axis_tdata);
          if (m_axis_tlast !== want.latch_after)
            flag_mismatch("tlast", want.latch_after, m_axis_tlast);
          if (m_axis_tuser !== want.rejected)
            flag_mismatch("tuser", want.rejected, m_axis_tuser);
        end
        bits_seen++;
      end
      if (out_stall > 0) begin
        out_stall     <= out_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (out_calm > 0) out_calm <= out_calm - 1;
        else if ($urandom_range(0, 5) == 0) out_stall <= pick_gap();
        else if ($urandom_range(0, 60) == 0) out_calm <= $urandom_range(20, 60);
      end
    end
  end

  initial begin
    logic [7:0] directed[20];
    directed = '{8'd0, 8'd11, 8'd22, 8'd33, 8'd44, 8'd55, 8'd66, 8'd77, 8'd88,
                 8'd99, 8'd10, 8'd9, 8'd5, 8'd100, 8'd101, 8'd127, 8'd128,
                 8'd254, 8'd255, 8'd90};
    foreach (directed[i]) pending_numbers.push_back(directed[i]);
    // mostly displayable values, the rest out of range
    for (int i = 0; i < 140; i++) begin
      if ($urandom_range(0, 4) == 0) pending_numbers.push_back(8'($urandom_range(100, 255)));
      else pending_numbers.push_back(8'($urandom_range(0, 99)));
    end
    total_numbers = pending_numbers.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_numbers < total_numbers || expected_bits.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d numbers sent (%0d rejected, %0d with blank tens), %0d bit transactions",
             sent_numbers, rejected_numbers, blanked_numbers, bits_seen);
    $display("%0d mismatches under random input gaps and output stalls", mismatches);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d bits still expected", expected_bits.size());
    $display("FAILURE");
    $finish;
  end

endmodule

/* two_digit_seven_segment_serializer_unit.f */
hw/rtl/tdss_pkg.sv
hw/rtl/tdss_encoder.sv
hw/rtl/tdss_shifter.sv
hw/rtl/two_digit_seven_segment_serializer_unit.sv
test/tb.sv
